// File: rtl/core/jsu_pkg.sv
// shared types and constants for the json string unescape block
`default_nettype none
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_UNTERM     = 4'd1;
  localparam logic [3:0] ERR_TRUNC_ESC  = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd3;
  localparam logic [3:0] ERR_CTRL       = 4'd4;
  localparam logic [3:0] ERR_TRUNC_U    = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX    = 4'd6;
  localparam logic [3:0] ERR_NO_LOW     = 4'd7;
  localparam logic [3:0] ERR_BAD_LOW    = 4'd8;
  localparam logic [3:0] ERR_LONE_LOW   = 4'd9;

  // utf-8 lead and continuation marks
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // one queued command: a code point with its byte count, a close or an error
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  code;
    logic [1:0]  nbytes_m1;
    logic [20:0] cp;
  } jsu_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/jsu_front.sv
// front end: escape and surrogate decoding, one input word per cycle while accept is high
`default_nettype none
module jsu_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             input_end,
  output logic                  push,
  output jsu_pkg::jsu_cmd_t     cmd
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX1,
    MODE_WAITBSL,
    MODE_WAITU,
    MODE_HEX2
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;

  mode_t       mode_r, mode_nxt;
  logic [11:0] accum_r, accum_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] hex_v;
  logic [10:0] plane;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      hex_d = data_byte[3:0];
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      hex_d = data_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_v = {accum_r, hex_d};
  // 0x10000 + (high << 10) + low, the add only touches the upper bits
  assign plane = {1'b0, hs_r} + 11'h040;

  always_comb begin
    mode_nxt   = mode_r;
    accum_nxt  = accum_r;
    digits_nxt = digits_r;
    hs_nxt     = hs_r;
    push       = 1'b0;
    cmd.kind      = KIND_BYTE;
    cmd.code      = ERR_NONE;
    cmd.nbytes_m1 = 2'd0;
    cmd.cp        = {13'd0, data_byte};

    if (accept) begin
      if (input_end) begin
        push     = 1'b1;
        cmd.kind = KIND_ERROR;
        cmd.cp   = 21'd0;
        case (mode_r)
          MODE_PLAIN: cmd.code = ERR_UNTERM;
          MODE_ESC:   cmd.code = ERR_TRUNC_ESC;
          MODE_HEX1:  cmd.code = ERR_TRUNC_U;
          default:    cmd.code = ERR_NO_LOW;
        endcase
      end else begin
        case (mode_r)
          MODE_ESC: begin
            push     = 1'b1;
            mode_nxt = MODE_PLAIN;
            case (data_byte)
              CH_QUOTE, CH_BSL, CH_SLASH: cmd.cp = {13'd0, data_byte};
              CH_B: cmd.cp = 21'h08;
              CH_F: cmd.cp = 21'h0C;
              CH_N: cmd.cp = 21'h0A;
              CH_R: cmd.cp = 21'h0D;
              CH_T: cmd.cp = 21'h09;
              CH_U: begin
                push       = 1'b0;
                mode_nxt   = MODE_HEX1;
                accum_nxt  = 12'd0;
                digits_nxt = 2'd0;
              end
              default: begin
                cmd.kind = KIND_ERROR;
                cmd.code = ERR_BAD_ESC;
                cmd.cp   = 21'd0;
              end
            endcase
          end
          MODE_HEX1, MODE_HEX2: begin
            if (!hex_ok) begin
              push     = 1'b1;
              cmd.kind = KIND_ERROR;
              cmd.code = ERR_BAD_HEX;
              cmd.cp   = 21'd0;
            end else if (digits_r != 2'd3) begin
              accum_nxt  = hex_v[11:0];
              digits_nxt = digits_r + 2'd1;
            end else begin
              accum_nxt  = 12'd0;
              digits_nxt = 2'd0;
              if (mode_r == MODE_HEX1) begin
                if (hex_v[15:10] == SURR_HIGH) begin
                  hs_nxt   = hex_v[9:0];
                  mode_nxt = MODE_WAITBSL;
                end else if (hex_v[15:10] == SURR_LOW) begin
                  push     = 1'b1;
                  cmd.kind = KIND_ERROR;
                  cmd.code = ERR_LONE_LOW;
                  cmd.cp   = 21'd0;
                end else begin
                  push     = 1'b1;
                  mode_nxt = MODE_PLAIN;
                  cmd.cp   = {5'd0, hex_v};
                  if (hex_v < 16'h0080) begin
                    cmd.nbytes_m1 = 2'd0;
                  end else if (hex_v < 16'h0800) begin
                    cmd.nbytes_m1 = 2'd1;
                  end else begin
                    cmd.nbytes_m1 = 2'd2;
                  end
                end
              end else begin
                push     = 1'b1;
                mode_nxt = MODE_PLAIN;
                if (hex_v[15:10] != SURR_LOW) begin
                  cmd.kind = KIND_ERROR;
                  cmd.code = ERR_BAD_LOW;
                  cmd.cp   = 21'd0;
                end else begin
                  cmd.cp        = {plane, hex_v[9:0]};
                  cmd.nbytes_m1 = 2'd3;
                end
              end
            end
          end
          MODE_WAITBSL: begin
            if (data_byte != CH_BSL) begin
              push     = 1'b1;
              cmd.kind = KIND_ERROR;
              cmd.code = ERR_NO_LOW;
              cmd.cp   = 21'd0;
            end else begin
              mode_nxt = MODE_WAITU;
            end
          end
          MODE_WAITU: begin
            if (data_byte != CH_U) begin
              push     = 1'b1;
              cmd.kind = KIND_ERROR;
              cmd.code = ERR_NO_LOW;
              cmd.cp   = 21'd0;
            end else begin
              mode_nxt   = MODE_HEX2;
              accum_nxt  = 12'd0;
              digits_nxt = 2'd0;
            end
          end
          default: begin
            if (data_byte == CH_QUOTE) begin
              push     = 1'b1;
              cmd.kind = KIND_CLOSE;
              cmd.cp   = 21'd0;
            end else if (data_byte == CH_BSL) begin
              mode_nxt = MODE_ESC;
            end else if (data_byte < CH_SPACE) begin
              push     = 1'b1;
              cmd.kind = KIND_ERROR;
              cmd.code = ERR_CTRL;
              cmd.cp   = 21'd0;
            end else begin
              push     = 1'b1;
              mode_nxt = MODE_PLAIN;
            end
          end
        endcase
      end

      // any close or error starts a fresh string
      if (push && cmd.kind != KIND_BYTE) begin
        mode_nxt   = MODE_PLAIN;
        accum_nxt  = 12'd0;
        digits_nxt = 2'd0;
        hs_nxt     = 10'd0;
      end
      if (push && mode_r == MODE_HEX2) begin
        hs_nxt = 10'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      accum_r  <= 12'd0;
      digits_r <= 2'd0;
      hs_r     <= 10'd0;
    end else begin
      mode_r   <= mode_nxt;
      accum_r  <= accum_nxt;
      digits_r <= digits_nxt;
      hs_r     <= hs_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/jsu_queue.sv
// short command queue between the front end and the byte serialiser
`default_nettype none
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire jsu_pkg::jsu_cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output jsu_pkg::jsu_cmd_t      head_cmd
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_cmd_t               entry_r [DEPTH];
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = entry_r[head_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
    end
    if (do_pop) begin
      head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[tail_r] <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue push lost");
`endif

endmodule
`default_nettype wire

// File: rtl/core/jsu_back.sv
// back end: serialises queued commands into result words
`default_nettype none
module jsu_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire jsu_pkg::jsu_cmd_t q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_result_kind,
  output logic [7:0]             out_out_byte,
  output logic [3:0]             out_error_code,
  output logic                   out_last
);
  import jsu_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic [3:0] code_r;
  logic       last_r;

  logic       load;
  logic       last_byte;
  logic [7:0] sel_byte;

  assign load      = q_valid && (!valid_r || !out_stall);
  assign last_byte = (idx_r == q_cmd.nbytes_m1);
  assign q_pop     = load && last_byte;

  always_comb begin
    sel_byte = 8'd0;
    if (q_cmd.kind == KIND_BYTE) begin
      case (q_cmd.nbytes_m1)
        2'd0: sel_byte = q_cmd.cp[7:0];
        2'd1: begin
          case (idx_r)
            2'd0:    sel_byte = UTF8_LEAD2 | {3'd0, q_cmd.cp[10:6]};
            default: sel_byte = UTF8_CONT | {2'd0, q_cmd.cp[5:0]};
          endcase
        end
        2'd2: begin
          case (idx_r)
            2'd0:    sel_byte = UTF8_LEAD3 | {4'd0, q_cmd.cp[15:12]};
            2'd1:    sel_byte = UTF8_CONT | {2'd0, q_cmd.cp[11:6]};
            default: sel_byte = UTF8_CONT | {2'd0, q_cmd.cp[5:0]};
          endcase
        end
        default: begin
          case (idx_r)
            2'd0:    sel_byte = UTF8_LEAD4 | {5'd0, q_cmd.cp[20:18]};
            2'd1:    sel_byte = UTF8_CONT | {2'd0, q_cmd.cp[17:12]};
            2'd2:    sel_byte = UTF8_CONT | {2'd0, q_cmd.cp[11:6]};
            default: sel_byte = UTF8_CONT | {2'd0, q_cmd.cp[5:0]};
          endcase
        end
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_byte ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // output word payload, held while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= q_cmd.kind;
      byte_r <= sel_byte;
      code_r <= q_cmd.code;
      last_r <= last_byte;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_out_byte    = byte_r;
  assign out_error_code  = code_r;
  assign out_last        = last_r;

`ifndef ASSERT_OFF
  a_single_word_end: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != KIND_BYTE) |-> (last_r && byte_r == 8'd0))
    else $error("close or error word not single");

  a_code_only_err: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != KIND_ERROR) |-> (code_r == ERR_NONE))
    else $error("error code on non-error word");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && idx_r != 2'd0) |-> (idx_r <= q_cmd.nbytes_m1))
    else $error("byte index past command length");
`endif

endmodule
`default_nettype wire

// File: rtl/core/json_string_unescape_utf8.sv
// top level of the json string unescape and utf-8 encode block
//
// input channel: one raw byte of a json string body per word (after the
// opening quote), or an end-of-input marker; in_valid/in_stall handshake.
// output channel: result words, each a decoded byte, a string close or an
// error code; out_last marks the final word caused by one input word.
// path: the first result of an input word passes the command queue, then
// the output register. throughput: one input word per cycle while the queue
// is not full and one result word per cycle while out_stall is low; a \u
// escape or surrogate pair emits up to four bytes, so the byte serialiser
// sets the rate on such input.
// a small command queue sits between the decoder and the serialiser; the
// input stalls only when that queue is full.
// reset clears decoder state, queue and output register; the next byte
// starts a new string. after a close or error the decoder likewise starts
// a new string. a stalled output holds its word, and the queue keeps
// taking input until it fills.
`default_nettype none
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_input_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_result_kind,
  output logic [7:0]      out_out_byte,
  output logic [3:0]      out_error_code,
  output logic            out_last
);
  import jsu_pkg::*;

  logic     accept;
  logic     push;
  jsu_cmd_t push_cmd;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  jsu_cmd_t head_cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .input_end (in_input_end),
    .push      (push),
    .cmd       (push_cmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_out_byte    (out_out_byte),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

// File: tb/json_unescape_checker.sv
// watches both channels of the json unescape block, predicts result words and compares them
module json_unescape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_input_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_result_kind,
  input  logic [7:0] out_out_byte,
  input  logic [3:0] out_error_code,
  input  logic       out_last,
  output int         fail_count,
  output int         words_due
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [2:0] {
    DEC_PLAIN, DEC_ESC, DEC_HEX1, DEC_WAIT_BSL, DEC_WAIT_U, DEC_HEX2
  } dec_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] code;
    logic       last;
  } result_word_t;

  result_word_t due_words[$];
  result_word_t step_words[$];

  dec_state_t  dec_state;
  logic [15:0] hex_acc;
  logic [1:0]  hex_cnt;
  logic [9:0]  high_bits;

  task automatic clear_decoder();
    dec_state = DEC_PLAIN;
    hex_acc   = '0;
    hex_cnt   = '0;
    high_bits = '0;
  endtask

  task automatic add_word(input logic [1:0] kind, input logic [7:0] data, input logic [3:0] code);
    result_word_t w;
    w.kind = kind;
    w.data = data;
    w.code = code;
    w.last = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic add_error(input logic [3:0] code);
    clear_decoder();
    add_word(KIND_ERROR, 8'h00, code);
  endtask

  task automatic add_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_word(KIND_BYTE, cp[7:0], ERR_NONE);
    end else if (cp < 21'h800) begin
      add_word(KIND_BYTE, UTF8_LEAD2 | {3'b0, cp[10:6]}, ERR_NONE);
      add_word(KIND_BYTE, UTF8_CONT | {2'b0, cp[5:0]}, ERR_NONE);
    end else if (cp < 21'h10000) begin
      add_word(KIND_BYTE, UTF8_LEAD3 | {4'b0, cp[15:12]}, ERR_NONE);
      add_word(KIND_BYTE, UTF8_CONT | {2'b0, cp[11:6]}, ERR_NONE);
      add_word(KIND_BYTE, UTF8_CONT | {2'b0, cp[5:0]}, ERR_NONE);
    end else begin
      add_word(KIND_BYTE, UTF8_LEAD4 | {5'b0, cp[20:18]}, ERR_NONE);
      add_word(KIND_BYTE, UTF8_CONT | {2'b0, cp[17:12]}, ERR_NONE);
      add_word(KIND_BYTE, UTF8_CONT | {2'b0, cp[11:6]}, ERR_NONE);
      add_word(KIND_BYTE, UTF8_CONT | {2'b0, cp[5:0]}, ERR_NONE);
    end
  endtask

  // top bit flags a valid hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      return {1'b1, d[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0;
  endfunction

  task automatic predict_word(input logic [7:0] c, input logic at_end);
    logic [4:0]   nib;
    logic [15:0]  v;
    result_word_t w;
    step_words.delete();
    if (at_end) begin
      case (dec_state)
        DEC_PLAIN: add_error(ERR_UNTERM);
        DEC_ESC:   add_error(ERR_TRUNC_ESC);
        DEC_HEX1:  add_error(ERR_TRUNC_U);
        default:   add_error(ERR_NO_LOW);
      endcase
    end else begin
      case (dec_state)
        DEC_ESC: begin
          dec_state = DEC_PLAIN;
          case (c)
            CH_QUOTE: add_word(KIND_BYTE, CH_QUOTE, ERR_NONE);
            CH_BSL:   add_word(KIND_BYTE, CH_BSL, ERR_NONE);
            "/":      add_word(KIND_BYTE, c, ERR_NONE);
            "b":      add_word(KIND_BYTE, 8'h08, ERR_NONE);
            "f":      add_word(KIND_BYTE, 8'h0C, ERR_NONE);
            "n":      add_word(KIND_BYTE, 8'h0A, ERR_NONE);
            "r":      add_word(KIND_BYTE, 8'h0D, ERR_NONE);
            "t":      add_word(KIND_BYTE, 8'h09, ERR_NONE);
            "u": begin
              dec_state = DEC_HEX1;
              hex_acc   = '0;
              hex_cnt   = '0;
            end
            default:  add_error(ERR_BAD_ESC);
          endcase
        end
        DEC_HEX1, DEC_HEX2: begin
          nib = hex_nibble(c);
          if (!nib[4]) begin
            add_error(ERR_BAD_HEX);
          end else begin
            v = {hex_acc[11:0], nib[3:0]};
            if (hex_cnt < 2'd3) begin
              hex_acc = v;
              hex_cnt = hex_cnt + 2'd1;
            end else begin
              hex_acc = '0;
              hex_cnt = '0;
              if (dec_state == DEC_HEX1) begin
                if (v >= 16'hD800 && v <= 16'hDBFF) begin
                  high_bits = v[9:0];
                  dec_state = DEC_WAIT_BSL;
                end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                  add_error(ERR_LONE_LOW);
                end else begin
                  dec_state = DEC_PLAIN;
                  add_utf8({5'b0, v});
                end
              end else if (v < 16'hDC00 || v > 16'hDFFF) begin
                add_error(ERR_BAD_LOW);
              end else begin
                // high and low halves each carry ten bits of the code point
                add_utf8(21'h10000 + {1'b0, high_bits, v[9:0]});
                clear_decoder();
              end
            end
          end
        end
        DEC_WAIT_BSL: begin
          if (c != CH_BSL) add_error(ERR_NO_LOW);
          else dec_state = DEC_WAIT_U;
        end
        DEC_WAIT_U: begin
          if (c != "u") begin
            add_error(ERR_NO_LOW);
          end else begin
            dec_state = DEC_HEX2;
            hex_acc   = '0;
            hex_cnt   = '0;
          end
        end
        default: begin
          if (c == CH_QUOTE) begin
            clear_decoder();
            add_word(KIND_CLOSE, 8'h00, ERR_NONE);
          end else if (c == CH_BSL) begin
            dec_state = DEC_ESC;
          end else if (c < 8'h20) begin
            add_error(ERR_CTRL);
          end else begin
            add_word(KIND_BYTE, c, ERR_NONE);
          end
        end
      endcase
    end
    foreach (step_words[i]) begin
      w = step_words[i];
      w.last = (i == step_words.size() - 1);
      due_words.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_words
    result_word_t exp_w;
    if (!rst_n) begin
      clear_decoder();
      due_words.delete();
      fail_count = 0;
      words_due <= 0;
    end else begin
      // results of a word accepted now cannot leave before the next edge
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          fail_count++;
          $error("unexpected result word: kind %0d byte %0h code %0d last %0d",
                 out_result_kind, out_out_byte, out_error_code, out_last);
        end else begin
          exp_w = due_words.pop_front();
          check_field("result_kind", exp_w.kind, out_result_kind);
          check_field("out_byte", exp_w.data, out_out_byte);
          check_field("error_code", exp_w.code, out_error_code);
          check_field("last", exp_w.last, out_last);
        end
      end
      if (in_valid && !in_stall) predict_word(in_data_byte, in_input_end);
      words_due <= due_words.size();
    end
  end

endmodule

// File: tb/tb.sv
// top of the json unescape testbench: clock, reset, word stimulus and verdict
module tb;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 310;
  localparam int PHASES       = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 200000;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef struct {
    logic [7:0] data;
    logic       at_end;
  } body_item_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_input_end = 1'b0;
  logic       out_stall    = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire [1:0]  out_result_kind;
  wire [7:0]  out_out_byte;
  wire [3:0]  out_error_code;
  wire        out_last;

  int   fail_count;
  int   words_due;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycles    = 0;

  body_item_t plan[$];

  always #5 clk = ~clk;

  json_string_unescape_utf8 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_input_end    (in_input_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_out_byte    (out_out_byte),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

  json_unescape_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_input_end    (in_input_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_out_byte    (out_out_byte),
    .out_error_code  (out_error_code),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .words_due       (words_due)
  );

  // receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("json_string_unescape_utf8 test failed");
      $finish;
    end
  end

  task automatic plan_byte(input logic [7:0] b);
    body_item_t it;
    it.data   = b;
    it.at_end = 1'b0;
    plan.push_back(it);
  endtask

  // end of input carries a junk byte that must be ignored
  task automatic plan_end();
    body_item_t it;
    it.data   = 8'($urandom_range(255));
    it.at_end = 1'b1;
    plan.push_back(it);
  endtask

  task automatic plan_hex(input logic [15:0] v, input int digits);
    logic [3:0] n;
    for (int i = 0; i < digits; i++) begin
      n = v[15 - 4 * i -: 4];
      if (n < 4'd10) plan_byte("0" + n);
      else if ($urandom_range(1)) plan_byte("a" + n - 8'd10);
      else plan_byte("A" + n - 8'd10);
    end
  endtask

  task automatic plan_escape_u(input logic [15:0] v);
    plan_byte(CH_BSL);
    plan_byte("u");
    plan_hex(v, 4);
  endtask

  task automatic plan_random_string();
    int          parts;
    int          k;
    logic [7:0]  b;
    logic [15:0] v;
    // a few strings of pure noise
    if ($urandom_range(19) == 0) begin
      parts = $urandom_range(1, 10);
      repeat (parts) begin
        if ($urandom_range(15) == 0) plan_end();
        else plan_byte(8'($urandom_range(255)));
      end
      return;
    end
    parts = $urandom_range(0, 8);
    repeat (parts) begin
      case ($urandom_range(9))
        5, 6: begin
          case ($urandom_range(7))
            0:       b = CH_QUOTE;
            1:       b = CH_BSL;
            2:       b = "/";
            3:       b = "b";
            4:       b = "f";
            5:       b = "n";
            6:       b = "r";
            default: b = "t";
          endcase
          plan_byte(CH_BSL);
          plan_byte(b);
        end
        7, 8: begin
          case ($urandom_range(3))
            0: v = 16'($urandom_range(16'h7F));
            1: v = 16'($urandom_range(16'h80, 16'h7FF));
            2: begin
              do v = 16'($urandom_range(16'h800, 16'hFFFF));
              while (v >= 16'hD800 && v <= 16'hDFFF);
            end
            default: begin
              case ($urandom_range(7))
                0:       v = 16'h0000;
                1:       v = 16'h007F;
                2:       v = 16'h0080;
                3:       v = 16'h07FF;
                4:       v = 16'h0800;
                5:       v = 16'hD7FF;
                6:       v = 16'hE000;
                default: v = 16'hFFFF;
              endcase
            end
          endcase
          plan_escape_u(v);
        end
        9: begin
          plan_escape_u(16'hD800 + 16'($urandom_range(10'h3FF)));
          plan_escape_u(16'hDC00 + 16'($urandom_range(10'h3FF)));
        end
        default: begin
          do b = 8'($urandom_range(8'h20, 8'hFF));
          while (b == CH_QUOTE || b == CH_BSL);
          plan_byte(b);
        end
      endcase
    end
    if ($urandom_range(99) < 65) begin
      plan_byte(CH_QUOTE);
      return;
    end
    k = $urandom_range(3);
    v = 16'hD800 + 16'($urandom_range(10'h3FF));
    case ($urandom_range(11))
      0: plan_end();
      1: plan_byte(8'($urandom_range(8'h1F)));
      2: begin
        plan_byte(CH_BSL);
        plan_end();
      end
      3: begin
        do b = 8'($urandom_range(255));
        while (b inside {CH_QUOTE, CH_BSL, "/", "b", "f", "n", "r", "t", "u"});
        plan_byte(CH_BSL);
        plan_byte(b);
      end
      4: begin
        plan_byte(CH_BSL);
        plan_byte("u");
        plan_hex(16'($urandom), k);
        plan_end();
      end
      5: begin
        do b = 8'($urandom_range(255));
        while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
        plan_byte(CH_BSL);
        plan_byte("u");
        plan_hex(16'($urandom), k);
        plan_byte(b);
      end
      6: begin
        plan_escape_u(v);
        plan_end();
      end
      7: begin
        do b = 8'($urandom_range(255));
        while (b == CH_BSL);
        plan_escape_u(v);
        plan_byte(b);
      end
      8: begin
        do b = 8'($urandom_range(255));
        while (b == "u");
        plan_escape_u(v);
        plan_byte(CH_BSL);
        plan_byte(b);
      end
      9: begin
        plan_escape_u(v);
        plan_byte(CH_BSL);
        plan_byte("u");
        plan_hex(16'($urandom), k);
        if ($urandom_range(1)) plan_end();
        else plan_byte("x");
      end
      10: begin
        plan_escape_u(v);
        do v = 16'($urandom);
        while (v >= 16'hDC00 && v <= 16'hDFFF);
        plan_escape_u(v);
      end
      default: plan_escape_u(16'hDC00 + 16'($urandom_range(10'h3FF)));
    endcase
  endtask

  // valid stays high from one word to the next unless an idle gap is drawn
  task automatic send_word(input body_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk);
      while ($urandom_range(99) < idle_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= it.data;
    in_input_end <= it.at_end;
    do @(posedge clk);
    while (in_stall);
  endtask

  task automatic send_plan();
    while (plan.size() > 0) send_word(plan.pop_front());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, the error paths other than surrogate errors, then the widest surrogate pair
    plan_byte(8'h20);
    plan_byte(8'hFF);
    plan_byte(8'h00);
    plan_end();
    plan_byte(CH_BSL);
    plan_byte(8'h00);
    plan_byte(CH_BSL);
    plan_end();
    plan_byte(CH_BSL);
    plan_byte("u");
    plan_end();
    plan_byte(CH_BSL);
    plan_byte("u");
    plan_byte("F");
    plan_byte("g");
    plan_escape_u(16'hDBFF);
    plan_escape_u(16'hDFFF);
    plan_byte(CH_QUOTE);
    send_plan();
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_req <= 1'b1;
        end
        1: begin
          idle_pct = 82;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 82;
        end
        default: begin
          idle_pct = 6;
          stall_pct <= 6;
        end
      endcase
      while (plan.size() < RANDOM_ITEMS / PHASES) plan_random_string();
      send_plan();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("json_string_unescape_utf8 test passed");
    end else begin
      $display("json_string_unescape_utf8 test failed");
    end
    $finish;
  end

endmodule
